// ----- rtl/asfc_pkg.sv -----
package asfc_pkg;
   localparam logic [2:0] FMT_PCM16 = 3'd0;
   localparam logic [2:0] FMT_PCM24 = 3'd1;
   localparam logic [2:0] FMT_PCM32 = 3'd2;
   localparam logic [2:0] FMT_F32   = 3'd3;
   localparam logic [2:0] FMT_F64   = 3'd4;
   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_ENCODE = 1'b1;

   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [2:0]  fmt;
      logic [63:0] raw;
      logic [31:0] fs;
   } beat_type;

   typedef struct packed {
      logic [31:0] fres;
      logic [63:0] rres;
      logic        clip;
   } res_type;
endpackage

// ----- rtl/audio_sample_format_converter_top.sv -----
// Audio sample format converter.
// Input: pulse start with req_cmd, req_raw_sample and req_float_sample; a
// beat is taken on any edge where start is high and busy is low. busy is
// always low, so one sample enters every cycle.
// Output: each result appears on rsp_* for one cycle with done high, once
// its beat has passed the three register stages (classify/align,
// shift/round, pack/saturate). Throughput is one sample per cycle.
// The receiver cannot stall; results are never held.
// Config: csr_valid/csr_ready write the stored format register
// (0 pcm16, 1 pcm24, 2 pcm32, 3 float32, 4 float64); csr_ready is always
// high. Write it only while no samples are in flight.
// Reset (synchronous) clears the format to pcm16 and drops all beats in
// the pipeline.
module audio_sample_format_converter_top
   import asfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [63:0] req_raw_sample,
   input  logic [31:0] req_float_sample,
   output logic        done,
   output logic [31:0] rsp_float_result,
   output logic [63:0] rsp_raw_result,
   output logic        rsp_clipped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);
   logic [2:0] fmt_ff;
   beat_type   beat;
   res_type    res;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // hold format register
   always_ff @(posedge clock) begin
      if (reset) fmt_ff <= FMT_PCM16;
      else if (csr_valid) fmt_ff <= csr_data;
   end

   assign beat = '{vld: start, cmd: req_cmd, fmt: fmt_ff,
                   raw: req_raw_sample, fs: req_float_sample};

   asfc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_beat (beat),
      .out_vld (done),
      .out_res (res)
   );

   assign rsp_float_result = res.fres;
   assign rsp_raw_result   = res.rres;
   assign rsp_clipped      = res.clip;
endmodule

// ----- rtl/asfc_core.sv -----
module asfc_core
   import asfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  beat_type in_beat,
   output logic     out_vld,
   output res_type  out_res
);
   // Stage 1: classify and align, stage 2: shift and round, stage 3: pack.

   // ---------------- stage 1 ----------------
   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [2:0]  fmt;
      logic        sgn;
      logic        spec;     // inf/nan/zero/direct result ready
      logic [63:0] spec_r;   // direct raw result
      logic [31:0] spec_f;   // direct float result
      logic        spec_c;
      logic [63:0] mant;     // value to shift right
      logic [6:0]  sh;       // right shift amount (0 means no shift)
      logic [7:0]  ex;       // exponent for int->float or narrow base
      logic [5:0]  nbits;
      logic [6:0]  lsh;      // left shift for pcm enc
      logic        lft;
      logic        sat;
   } s1_type;

   s1_type s1_in, s1_ff;

   function automatic logic [5:0] lz32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) if (v[i]) n = 6'(31 - i);
      return n;
   endfunction

   always_comb begin
      logic [31:0] mag32;
      logic [31:0] sv;
      logic [5:0]  lz;
      logic [7:0]  e;
      logic [23:0] m;
      logic [10:0] de;
      logic signed [12:0] te;
      logic signed [9:0] s;
      s1_in = '0;
      s1_in.vld = in_beat.vld;
      s1_in.cmd = in_beat.cmd;
      s1_in.fmt = in_beat.fmt;
      sv = '0; mag32 = '0; lz = '0; m = '0; e = '0; de = '0; te = '0; s = '0;
      if (in_beat.cmd == CMD_DECODE) begin
         unique case (in_beat.fmt)
            FMT_PCM16, FMT_PCM24, FMT_PCM32: begin
               // sign-extend to 32 bits, take magnitude, normalize
               if (in_beat.fmt == FMT_PCM16) sv = {{16{in_beat.raw[15]}}, in_beat.raw[15:0]};
               else if (in_beat.fmt == FMT_PCM24)
                  sv = {{8{in_beat.raw[23]}}, in_beat.raw[23:0]};
               else sv = in_beat.raw[31:0];
               s1_in.sgn = sv[31];
               mag32 = sv[31] ? (~sv + 32'd1) : sv;
               lz = lz32(mag32);
               if (mag32 == '0) begin
                  s1_in.spec = 1'b1;
                  s1_in.spec_f = '0;
               end else begin
                  // value = mag * 2^-(N-1); msb at 31-lz
                  s1_in.mant = {32'(mag32 << lz), 32'd0};
                  s1_in.sh = 7'd40;  // keep 24 bits of 64
                  unique case (in_beat.fmt)
                     FMT_PCM16: s1_in.ex = 8'(127 + 31 - 15) - 8'(lz);
                     FMT_PCM24: s1_in.ex = 8'(127 + 31 - 23) - 8'(lz);
                     default:   s1_in.ex = 8'(127 + 31 - 31) - 8'(lz);
                  endcase
               end
            end
            FMT_F32: begin
               s1_in.spec = 1'b1;
               s1_in.spec_f = in_beat.raw[31:0];
            end
            FMT_F64: begin
               s1_in.sgn = in_beat.raw[63];
               de = in_beat.raw[62:52];
               te = 13'(de) - 13'sd896;
               if (de == 11'h7FF) begin
                  s1_in.spec = 1'b1;
                  s1_in.spec_f = (in_beat.raw[51:0] == '0) ? {in_beat.raw[63], 31'h7F800000}
                     : {in_beat.raw[63], 31'h7FC00000} | {10'd0, in_beat.raw[50:29]};
               end else if (de == '0 || te >= 13'sd255 || te <= -13'sd24) begin
                  s1_in.spec = 1'b1;
                  s1_in.spec_f = (de != '0 && te >= 13'sd255) ?
                     {in_beat.raw[63], 31'h7F800000} : {in_beat.raw[63], 31'd0};
               end else begin
                  s1_in.mant = {11'd0, 1'b1, in_beat.raw[51:0]};
                  if (te >= 13'sd1) begin
                     s1_in.sh = 7'd29;
                     s1_in.ex = 8'(te - 13'sd1);
                  end else begin
                     s1_in.sh = 7'(13'sd30 - te);
                     s1_in.ex = '0;
                  end
               end
            end
            default: begin
               s1_in.spec = 1'b1;
            end
         endcase
      end else begin
         e = in_beat.fs[30:23];
         unique case (in_beat.fmt)
            FMT_PCM16, FMT_PCM24, FMT_PCM32: begin
               s1_in.sgn = in_beat.fs[31];
               s1_in.nbits = (in_beat.fmt == FMT_PCM16) ? 6'd16 :
                             (in_beat.fmt == FMT_PCM24) ? 6'd24 : 6'd32;
               if (e == 8'hFF && in_beat.fs[22:0] != '0) begin
                  s1_in.spec = 1'b1;
                  s1_in.spec_c = 1'b1;
               end else if (e == 8'hFF) begin
                  s1_in.sat = 1'b1;
               end else begin
                  m = {(e != 0), in_beat.fs[22:0]};
                  if (e == 0) e = 8'd1;
                  s = 10'(e) - 10'sd151 + 10'(s1_in.nbits);
                  if (m == '0) s1_in.mant = '0;
                  else if (s >= 10'sd32) s1_in.sat = 1'b1;
                  else if (s >= 0) begin
                     s1_in.lft = 1'b1;
                     s1_in.lsh = 7'(s);
                     s1_in.mant = {40'd0, m};
                  end else if (s <= -10'sd40) s1_in.mant = '0;
                  else begin
                     s1_in.mant = {40'd0, m};
                     s1_in.sh = 7'(-s);
                  end
               end
            end
            FMT_F32: begin
               s1_in.spec = 1'b1;
               s1_in.spec_r = {32'd0, in_beat.fs};
               if (e == 8'hFF && in_beat.fs[22:0] != '0) s1_in.spec_r[22] = 1'b1;
            end
            FMT_F64: begin
               s1_in.spec = 1'b1;
               if (e == 8'hFF) begin
                  s1_in.spec_r = (in_beat.fs[22:0] == '0) ?
                     {in_beat.fs[31], 63'h7FF0000000000000} :
                     ({in_beat.fs[31], 63'h7FF8000000000000} | {12'd0, in_beat.fs[22:0], 29'd0});
               end else if (e == 0) begin
                  if (in_beat.fs[22:0] == '0) s1_in.spec_r = {in_beat.fs[31], 63'd0};
                  else begin
                     lz = lz32({9'd0, in_beat.fs[22:0]});
                     // leading one moves to bit 23; exponent 897-(lz-8)
                     m = 24'({in_beat.fs[22:0]} << (lz - 6'd8));
                     s1_in.spec_r = {in_beat.fs[31], 11'(11'd905 - 11'(lz)), m[22:0], 29'd0};
                  end
               end else
                  s1_in.spec_r = {in_beat.fs[31], 11'(11'(e) + 11'd896),
                                  in_beat.fs[22:0], 29'd0};
            end
            default: s1_in.spec = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff.vld <= 1'b0;
      else s1_ff <= s1_in;
   end

   // ---------------- stage 2 ----------------
   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [2:0]  fmt;
      logic        sgn;
      logic        spec;
      logic [63:0] spec_r;
      logic [31:0] spec_f;
      logic        spec_c;
      logic [63:0] q;
      logic        inc;
      logic [7:0]  ex;
      logic [5:0]  nbits;
      logic        sat;
   } s2_type;

   s2_type s2_in, s2_ff;

   always_comb begin
      logic [63:0] rem, half;
      s2_in = '0;
      s2_in.vld = s1_ff.vld;
      s2_in.cmd = s1_ff.cmd;
      s2_in.fmt = s1_ff.fmt;
      s2_in.sgn = s1_ff.sgn;
      s2_in.spec = s1_ff.spec;
      s2_in.spec_r = s1_ff.spec_r;
      s2_in.spec_f = s1_ff.spec_f;
      s2_in.spec_c = s1_ff.spec_c;
      s2_in.ex = s1_ff.ex;
      s2_in.nbits = s1_ff.nbits;
      s2_in.sat = s1_ff.sat;
      rem = '0; half = '0;
      if (s1_ff.lft) begin
         s2_in.q = s1_ff.mant << s1_ff.lsh[5:0];
      end else if (s1_ff.sh != '0) begin
         s2_in.q = s1_ff.mant >> s1_ff.sh[5:0];
         rem = s1_ff.mant & ((64'd1 << s1_ff.sh[5:0]) - 64'd1);
         half = 64'd1 << (s1_ff.sh[5:0] - 6'd1);
         if (s1_ff.cmd == CMD_ENCODE)
            s2_in.inc = s1_ff.sgn ? (rem > half) : (rem >= half);
         else
            s2_in.inc = (rem > half) || (rem == half && s2_in.q[0]);
      end else s2_in.q = s1_ff.mant;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_ff.vld <= 1'b0;
      else s2_ff <= s2_in;
   end

   // ---------------- stage 3 ----------------
   res_type res_in, res_ff;
   logic    vld_ff;

   always_comb begin
      logic [63:0] qr, lim, mask, mag;
      logic [32:0] r;
      res_in = '0;
      qr = s2_ff.q + 64'(s2_ff.inc);
      lim = 64'd1 << (s2_ff.nbits - 6'd1);
      mask = (s2_ff.nbits == 6'd32) ? 64'hFFFF_FFFF : ((64'd1 << s2_ff.nbits) - 64'd1);
      mag = s2_ff.sat ? '1 : qr;
      r = '0;
      if (s2_ff.spec) begin
         res_in.fres = s2_ff.spec_f;
         res_in.rres = s2_ff.spec_r;
         res_in.clip = s2_ff.spec_c;
      end else if (s2_ff.cmd == CMD_DECODE) begin
         if (s2_ff.fmt == FMT_F64) begin
            r = 33'({s2_ff.ex, 23'd0}) + 33'(qr);
            res_in.fres = (r >= 33'h7F800000) ? {s2_ff.sgn, 31'h7F800000}
                          : {s2_ff.sgn, r[30:0]};
         end else begin
            // qr holds 24-bit mantissa, may carry to 2^24
            if (qr[24]) res_in.fres = {s2_ff.sgn, 8'(s2_ff.ex + 8'd1), 23'd0};
            else res_in.fres = {s2_ff.sgn, s2_ff.ex, qr[22:0]};
         end
      end else begin
         if (s2_ff.sgn) begin
            if (mag > lim) begin res_in.clip = 1'b1; mag = lim; end
            res_in.rres = (64'd0 - mag) & mask;
         end else begin
            if (mag > lim - 64'd1) begin res_in.clip = 1'b1; mag = lim - 64'd1; end
            res_in.rres = mag & mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= s2_ff.vld;
      res_ff <= res_in;
   end

   assign out_vld = vld_ff;
   assign out_res = res_ff;
endmodule

// ----- rtl/asfc_checker.sv -----
module asfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        done,
   input logic [31:0] rsp_float_result,
   input logic [63:0] rsp_raw_result,
   input logic        rsp_clipped
);
   // every beat taken must show its result with done high
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 done) else $error("result missing");
   a_nospur: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(start && !busy, 3)) else $error("spurious result");
   a_dec: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_float_result != '0) |-> (rsp_raw_result == '0 && !rsp_clipped))
      else $error("decode result mixed with encode fields");
endmodule

bind audio_sample_format_converter_top asfc_checker u_chk (.*);

// ----- verif/tb_audio_sample_format_converter_top.sv -----
module tb_audio_sample_format_converter_top;
   import asfc_pkg::*;

   localparam int PERIOD = 4;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_DECODE;
   logic [63:0] req_raw_sample = '0;
   logic [31:0] req_float_sample = '0;
   logic        done;
   logic [31:0] rsp_float_result;
   logic [63:0] rsp_raw_result;
   logic        rsp_clipped;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data = '0;

   audio_sample_format_converter_top i_dut (.*);

   always #(PERIOD / 2) clock = ~clock;

   // sample format as the testbench believes it to be
   logic [2:0] cur_fmt;
   res_type    pending_samples[$];
   int         error_count = 0;
   bit         idling_on = 1'b1;

   typedef struct {
      logic [2:0]  fmt;
      logic        cmd;
      logic [63:0] raw;
      logic [31:0] fs;
      bit          typed;
      res_type     want;
   } stim_row_type;

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // signed integer times 2^-k to float32 bits, round to nearest even
   function automatic logic [31:0] int_to_f32(logic signed [31:0] s, int k);
      logic [32:0] mag;
      logic [32:0] q;
      logic [32:0] rem;
      logic [32:0] half;
      int          p;
      int          sh;
      if (s == 0) return 32'h0;
      mag = s[31] ? (33'd0 - {s[31], s}) : {1'b0, s};
      p = 0;
      for (int i = 0; i < 33; i++) if (mag[i]) p = i;
      if (p <= 23) begin
         q = mag << (23 - p);
      end else begin
         sh = p - 23;
         q = mag >> sh;
         rem = mag & ((33'd1 << sh) - 1);
         half = 33'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q++;
         if (q[24]) begin
            q = q >> 1;
            p++;
         end
      end
      return {s[31], 8'(p + 127 - k), q[22:0]};
   endfunction

   // float64 bits down to float32, round to nearest even
   function automatic logic [31:0] f64_to_f32(logic [63:0] d);
      logic [31:0] sgn;
      logic [10:0] e;
      logic [63:0] full;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] base;
      logic [63:0] r;
      int          te;
      int          sh;
      sgn = {d[63], 31'h0};
      e = d[62:52];
      if (e == 11'h7FF) begin
         if (d[51:0] == 0) return sgn | 32'h7F800000;
         return sgn | 32'h7FC00000 | {10'h0, d[50:29]};
      end
      if (e == 0) return sgn;
      full = {11'h0, 1'b1, d[51:0]};
      te = int'(e) - 896;
      if (te >= 255) return sgn | 32'h7F800000;
      sh = 29;
      base = 0;
      if (te >= 1) begin
         base = 64'(te - 1) << 23;
      end else begin
         if (1 - te >= 25) return sgn;
         sh = 29 + 1 - te;
      end
      q = full >> sh;
      rem = full & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      r = base + q;
      if (r >= 64'h7F800000) return sgn | 32'h7F800000;
      return sgn | r[31:0];
   endfunction

   // float32 bits up to float64, exact
   function automatic logic [63:0] f32_to_f64(logic [31:0] f);
      logic [63:0] sgn;
      logic [63:0] m;
      logic [63:0] ex;
      sgn = {f[31], 63'h0};
      m = {41'h0, f[22:0]};
      if (f[30:23] == 8'hFF) begin
         if (m == 0) return sgn | 64'h7FF0000000000000;
         return sgn | 64'h7FF8000000000000 | (m << 29);
      end
      if (f[30:23] == 0) begin
         if (m == 0) return sgn;
         ex = 897;
         while (!m[23]) begin
            m = m << 1;
            ex--;
         end
         return sgn | (ex << 52) | ((m & 64'h7FFFFF) << 29);
      end
      return sgn | (64'(f[30:23] + 896) << 52) | (m << 29);
   endfunction

   // float32 to n-bit PCM: floor(x * 2^(n-1) + 0.5), saturated
   function automatic logic [63:0] f32_to_pcm(logic [31:0] f, int n, output logic clip);
      logic [63:0] m;
      logic [63:0] lim;
      logic [63:0] mask;
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          s;
      int          sh;
      m = {41'h0, f[22:0]};
      e = int'(f[30:23]);
      lim = 64'd1 << (n - 1);
      mask = (n == 64) ? '1 : ((64'd1 << n) - 1);
      clip = 1'b0;
      if (e == 255 && m != 0) begin
         clip = 1'b1;
         return 64'h0;
      end
      if (e == 255) begin
         mag = '1;
      end else begin
         if (e != 0) m[23] = 1'b1;
         else e = 1;
         s = e - 150 + n - 1;
         if (m == 0) mag = 0;
         else if (s >= 32) mag = '1;
         else if (s >= 0) mag = m << s;
         else begin
            sh = -s;
            if (sh >= 40) begin
               mag = 0;
            end else begin
               q = m >> sh;
               rem = m & ((64'd1 << sh) - 1);
               half = 64'd1 << (sh - 1);
               if (f[31] ? (rem > half) : (rem >= half)) q++;
               mag = q;
            end
         end
      end
      if (f[31]) begin
         if (mag > lim) begin
            clip = 1'b1;
            mag = lim;
         end
         return (64'd0 - mag) & mask;
      end
      if (mag > lim - 1) begin
         clip = 1'b1;
         mag = lim - 1;
      end
      return mag & mask;
   endfunction

   function automatic res_type convert_sample(logic [2:0] fmt, logic cmd, logic [63:0] raw,
                                              logic [31:0] fs);
      res_type r;
      r = '0;
      if (cmd == CMD_DECODE) begin
         case (fmt)
            FMT_PCM16: r.fres = int_to_f32(32'(signed'(raw[15:0])), 15);
            FMT_PCM24: r.fres = int_to_f32(32'(signed'(raw[23:0])), 23);
            FMT_PCM32: r.fres = int_to_f32(raw[31:0], 31);
            FMT_F32:   r.fres = raw[31:0];
            FMT_F64:   r.fres = f64_to_f32(raw);
            default:   r.fres = '0;
         endcase
      end else begin
         case (fmt)
            FMT_PCM16: r.rres = f32_to_pcm(fs, 16, r.clip);
            FMT_PCM24: r.rres = f32_to_pcm(fs, 24, r.clip);
            FMT_PCM32: r.rres = f32_to_pcm(fs, 32, r.clip);
            FMT_F32: begin
               r.rres = {32'h0, fs};
               if (fs[30:23] == 8'hFF && fs[22:0] != 0) r.rres[22] = 1'b1;
            end
            FMT_F64: r.rres = f32_to_f64(fs);
            default: r.rres = '0;
         endcase
      end
      return r;
   endfunction

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      res_type want;
      if (!reset && done) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected result beat", 64'd1, 64'd0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_float_result !== want.fres)
               report_mismatch("float_result", 64'(rsp_float_result), 64'(want.fres));
            if (rsp_raw_result !== want.rres)
               report_mismatch("raw_result", rsp_raw_result, want.rres);
            if (rsp_clipped !== want.clip)
               report_mismatch("clipped", 64'(rsp_clipped), 64'(want.clip));
         end
      end
   end

   // hold off until every sample has come back, then let the pipe settle
   task automatic drain_samples();
      start = 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_format(logic [2:0] fmt);
      drain_samples();
      csr_valid = 1'b1;
      csr_data = fmt;
      do @(posedge clock); while (!csr_ready);
      cur_fmt = fmt;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drive one sample beat; returns at the falling edge after acceptance, or after a random idle gap
   task automatic send_sample(logic cmd, logic [63:0] raw, logic [31:0] fs,
                              bit typed, res_type want);
      start = 1'b1;
      req_cmd = cmd;
      req_raw_sample = raw;
      req_float_sample = fs;
      do @(posedge clock); while (busy);
      pending_samples.push_back(typed ? want : convert_sample(cur_fmt, cmd, raw, fs));
      @(negedge clock);
      if (idling_on && $urandom_range(3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_float();
      logic [31:0] f;
      f = $urandom;
      case ($urandom_range(9))
         0, 1: ;
         2, 3, 4: f[30:23] = 8'($urandom_range(100, 160));
         5: f[30:0] = {8'($urandom_range(120, 158)), 23'h0};
         6: f[30:23] = 8'hFF;
         7: f[30:23] = 8'h00;
         8: f[22:0] = $urandom_range(1) ? 23'h0 : 23'h7FFFFF;
         default: f[30:0] = 31'($urandom_range(1)) << $urandom_range(30);
      endcase
      return f;
   endfunction

   function automatic logic [63:0] random_raw(logic [2:0] fmt);
      logic [63:0] d;
      d = {$urandom, $urandom};
      if (fmt == FMT_F64) begin
         case ($urandom_range(7))
            0: ;
            1, 2, 3: d[62:52] = 11'($urandom_range(860, 1160));
            4: d[62:52] = 11'h7FF;
            5: d[62:52] = 11'h000;
            6: d[28:0] = {1'($urandom_range(1)), 28'h0};
            default: d[62:52] = 11'($urandom_range(1145, 1152));
         endcase
      end else if ($urandom_range(4) == 0) begin
         d[31:0] = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         d[31:0] = d[31:0] ^ 32'($urandom_range(3));
      end
      return d;
   endfunction

   stim_row_type directed[$];

   function automatic void add_row(logic [2:0] fmt, logic cmd, logic [63:0] raw,
                                   logic [31:0] fs, bit typed, logic [31:0] fres,
                                   logic [63:0] rres, logic clip);
      stim_row_type r;
      r.fmt = fmt;
      r.cmd = cmd;
      r.raw = raw;
      r.fs = fs;
      r.typed = typed;
      r.want = '{fres: fres, rres: rres, clip: clip};
      directed.push_back(r);
   endfunction

   initial begin
      logic [2:0] fmt_plan[] = '{FMT_PCM16, FMT_PCM24, FMT_PCM32, FMT_F32, FMT_F64, 3'd5,
                                 FMT_PCM32, FMT_F64, 3'd7, FMT_PCM16, FMT_F32, FMT_PCM24};
      int per_phase;
      logic cmd;

      // reset state is pcm16
      add_row(FMT_PCM16, CMD_DECODE, 64'h8000, 0, 1, 32'hBF800000, 0, 0);
      add_row(FMT_PCM16, CMD_DECODE, 64'hFFFF_FFFF_FFFF_7FFF, 0, 0, 0, 0, 0);
      add_row(FMT_PCM16, CMD_DECODE, 64'h0, 0, 1, 32'h0, 0, 0);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'h3F800000, 1, 0, 64'h7FFF, 1);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'hBF800000, 1, 0, 64'h8000, 0);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'h3F000000, 1, 0, 64'h4000, 0);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'h7FC00001, 1, 0, 64'h0, 1);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'h7F800000, 1, 0, 64'h7FFF, 1);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'hFF800000, 1, 0, 64'h8000, 1);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'h38000000, 0, 0, 0, 0);
      add_row(FMT_PCM16, CMD_ENCODE, 0, 32'hB8000000, 0, 0, 0, 0);
      add_row(FMT_PCM24, CMD_DECODE, 64'hABCD_0000_0080_0000, 0, 1, 32'hBF800000, 0, 0);
      add_row(FMT_PCM24, CMD_ENCODE, 0, 32'hFFFFFFFF, 1, 0, 64'h0, 1);
      add_row(FMT_PCM32, CMD_DECODE, 64'h7FFFFFFF, 0, 1, 32'h3F800000, 0, 0);
      add_row(FMT_PCM32, CMD_ENCODE, 0, 32'hBF800000, 1, 0, 64'h80000000, 0);
      add_row(FMT_F32, CMD_ENCODE, 0, 32'h7F800001, 1, 0, 64'h7FC00001, 0);
      add_row(FMT_F32, CMD_DECODE, 64'hFFFF_FFFF_1234_5678, 0, 1, 32'h12345678, 0, 0);
      add_row(FMT_F64, CMD_DECODE, 64'h8000000000000001, 0, 1, 32'h80000000, 0, 0);
      add_row(FMT_F64, CMD_DECODE, 64'h7FF0000000000001, 0, 1, 32'h7FC00000, 0, 0);
      add_row(FMT_F64, CMD_DECODE, 64'hFFF0000000000000, 0, 1, 32'hFF800000, 0, 0);
      add_row(FMT_F64, CMD_DECODE, 64'h47F0000000000000, 0, 1, 32'h7F800000, 0, 0);
      add_row(FMT_F64, CMD_DECODE, 64'h3690000000000000, 0, 0, 0, 0, 0);
      add_row(FMT_F64, CMD_ENCODE, 0, 32'h3F800000, 1, 0, 64'h3FF0000000000000, 0);
      add_row(FMT_F64, CMD_ENCODE, 0, 32'h00000001, 0, 0, 0, 0);
      add_row(3'd7, CMD_DECODE, '1, 32'hFFFFFFFF, 1, 0, 0, 0);
      add_row(3'd6, CMD_ENCODE, '1, 32'hBF800000, 1, 0, 0, 0);

      cur_fmt = FMT_PCM16;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      foreach (directed[i]) begin
         if (directed[i].fmt != cur_fmt) write_format(directed[i].fmt);
         send_sample(directed[i].cmd, directed[i].raw, directed[i].fs,
                     directed[i].typed, directed[i].want);
      end

      // random phases; the last two run without random idle gaps
      per_phase = 1500 / fmt_plan.size();
      foreach (fmt_plan[p]) begin
         write_format(fmt_plan[p]);
         if (p >= fmt_plan.size() - 2) idling_on = 1'b0;
         for (int n = 0; n < per_phase; n++) begin
            if (n == per_phase / 2) drain_samples();
            cmd = 1'($urandom_range(1));
            send_sample(cmd, random_raw(cur_fmt), random_float(), 0, '0);
         end
      end

      drain_samples();
      if (error_count == 0) $display("audio_sample_format_converter_top test passed");
      else $display("audio_sample_format_converter_top test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("audio_sample_format_converter_top test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/asfc_pkg.sv
rtl/asfc_core.sv
rtl/audio_sample_format_converter_top.sv
rtl/asfc_checker.sv
verif/tb_audio_sample_format_converter_top.sv
